### src/wpid_pkg.sv
// Shared types and constants for the wheel PID speed controller.
// Used by the controller, the datapath and the divider; depends on nothing.
`default_nettype none

package wpid_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned STEP_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_RANGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_FULL   = 3'd4;

	localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
	localparam logic [15:0] INTEG_GAIN_RST = 16'd0;
	localparam logic [15:0] DERIV_GAIN_RST = 16'd0;
	localparam logic [11:0] RPM_RANGE_RST  = 12'd300;
	localparam logic [15:0] PWM_FULL_RST   = 16'd255;

	localparam logic signed [7:0] CMD_MAX = 8'sd100;
	localparam logic signed [7:0] CMD_MIN = -8'sd100;

	localparam logic [15:0] PCT_DIVISOR = 16'd100;
	localparam logic [15:0] MS_PER_S    = 16'd1000;

	localparam logic signed [47:0] ACC_POS_LIM = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] ACC_NEG_LIM = 48'sh8000_0000_0001;

	// Radix-4 divider steps: each step retires two quotient bits.
	localparam logic [STEP_W-1:0] STEPS_TGT  = 6'd10;
	localparam logic [STEP_W-1:0] STEPS_INT  = 6'd32;
	localparam logic [STEP_W-1:0] STEPS_DER  = 6'd20;
	localparam logic [STEP_W-1:0] STEPS_DUTY = 6'd14;

	typedef enum logic [2:0] {
		MUL_TGT,
		MUL_ERR_MS,
		MUL_PROP,
		MUL_INT_LO,
		MUL_INT_HI,
		MUL_DER_SCALE,
		MUL_DER_GAIN,
		MUL_DUTY
	} mul_sel_t;

	typedef enum logic [1:0] {
		DIV_TGT,
		DIV_INT,
		DIV_DER,
		DIV_DUTY
	} div_sel_t;

	typedef struct packed {
		logic     in_load;
		logic     stop;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     int_hold;
		logic     int_comb;
		logic     div_start;
		div_sel_t div_sel;
		logic     tgt_load;
		logic     acc_upd;
		logic     sum_load_p;
		logic     sum_add_i;
		logic     sum_add_d;
		logic     pid_load;
		logic     duty_zero;
		logic     duty_load;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic cmd_zero;
		logic ms_zero;
		logic duty_pos;
	} dp_sts_t;

endpackage

`default_nettype wire

### src/wheel_pid_speed_controller_top.sv
// Wheel PID speed controller: one result beat per accepted input beat, one item at a time.
// The shared radix-4 divider performs the target, integral, derivative and duty divisions
// in turn for a nonzero command; the derivative one is skipped with zero elapsed time and
// the duty one for a zero duty; a stop command needs none. A new item is accepted only
// once the last result is loaded; a stalled result holds back the item after the next.
// Reset restores default gains, clears the integrator and last error, selects forward.
`default_nettype none

module wheel_pid_speed_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic signed [7:0]               speed_cmd,
	input  logic signed [12:0]              measured_rpm,
	input  logic [15:0]                     elapsed_ms,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [15:0]                     pwm_duty,
	output logic                            dir_forward
);

	wpid_pkg::dp_cmd_t cmd;
	wpid_pkg::dp_sts_t sts;

	wpid_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	wpid_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.speed_cmd    (speed_cmd),
		.measured_rpm (measured_rpm),
		.elapsed_ms   (elapsed_ms),
		.cmd          (cmd),
		.sts          (sts),
		.pwm_duty     (pwm_duty),
		.dir_forward  (dir_forward)
	);

endmodule

`default_nettype wire

### src/wpid_div.sv
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
// Takes a left-aligned 64-bit dividend and a 16-bit divisor; uses wpid_pkg.
`default_nettype none

module wpid_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                dividend,
	input  logic [15:0]                divisor,
	input  logic [wpid_pkg::STEP_W-1:0] steps,
	output logic                       done,
	output logic [63:0]                quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [wpid_pkg::STEP_W-1:0] cnt_q;
	logic [15:0]                 rem_q;
	logic [15:0]                 div_q;
	logic [63:0]                 quo_q;

	logic [16:0] r1;
	logic [16:0] r2;
	logic [15:0] r1n;
	logic [15:0] r2n;
	logic        b1;
	logic        b2;

	always_comb begin
		r1  = {rem_q, quo_q[63]};
		b1  = r1 >= {1'b0, div_q};
		r1n = b1 ? 16'(r1 - {1'b0, div_q}) : r1[15:0];
		r2  = {r1n, quo_q[62]};
		b2  = r2 >= {1'b0, div_q};
		r2n = b2 ? 16'(r2 - {1'b0, div_q}) : r2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wpid_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= r2n;
			quo_q <= {quo_q[61:0], b1, b2};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### src/wpid_ctrl.sv
// Sequencing state machine for the wheel PID speed controller.
// Drives the datapath through wpid_pkg command and status structs.
`default_nettype none

module wpid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  wpid_pkg::dp_sts_t sts,
	output wpid_pkg::dp_cmd_t cmd
);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_STOP      = 5'd1;
	localparam logic [4:0] ST_TGT_MUL   = 5'd2;
	localparam logic [4:0] ST_TGT_DIV   = 5'd3;
	localparam logic [4:0] ST_TGT_WAIT  = 5'd4;
	localparam logic [4:0] ST_EM_MUL    = 5'd5;
	localparam logic [4:0] ST_P_MUL     = 5'd6;
	localparam logic [4:0] ST_I_LO      = 5'd7;
	localparam logic [4:0] ST_I_HI      = 5'd8;
	localparam logic [4:0] ST_I_COMB    = 5'd9;
	localparam logic [4:0] ST_I_DIV     = 5'd10;
	localparam logic [4:0] ST_I_WAIT    = 5'd11;
	localparam logic [4:0] ST_D_SCALE   = 5'd12;
	localparam logic [4:0] ST_D_GAIN    = 5'd13;
	localparam logic [4:0] ST_D_DIV     = 5'd14;
	localparam logic [4:0] ST_D_WAIT    = 5'd15;
	localparam logic [4:0] ST_PID       = 5'd16;
	localparam logic [4:0] ST_DUTY_MUL  = 5'd17;
	localparam logic [4:0] ST_DUTY_DIV  = 5'd18;
	localparam logic [4:0] ST_DUTY_WAIT = 5'd19;
	localparam logic [4:0] ST_OUT       = 5'd20;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       result_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.in_load = 1'b1;
					state_d     = sts.cmd_zero ? ST_STOP : ST_TGT_MUL;
				end
			end
			ST_STOP: begin
				cmd.stop = 1'b1;
				state_d  = ST_OUT;
			end
			ST_TGT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wpid_pkg::MUL_TGT;
				state_d     = ST_TGT_DIV;
			end
			ST_TGT_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = wpid_pkg::DIV_TGT;
				state_d       = ST_TGT_WAIT;
			end
			ST_TGT_WAIT: begin
				if (sts.div_done) begin
					cmd.tgt_load = 1'b1;
					state_d      = ST_EM_MUL;
				end
			end
			ST_EM_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wpid_pkg::MUL_ERR_MS;
				state_d     = ST_P_MUL;
			end
			ST_P_MUL: begin
				cmd.acc_upd = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wpid_pkg::MUL_PROP;
				state_d     = ST_I_LO;
			end
			ST_I_LO: begin
				cmd.sum_load_p = 1'b1;
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = wpid_pkg::MUL_INT_LO;
				state_d        = ST_I_HI;
			end
			ST_I_HI: begin
				cmd.int_hold = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = wpid_pkg::MUL_INT_HI;
				state_d      = ST_I_COMB;
			end
			ST_I_COMB: begin
				cmd.int_comb = 1'b1;
				state_d      = ST_I_DIV;
			end
			ST_I_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = wpid_pkg::DIV_INT;
				state_d       = ST_I_WAIT;
			end
			ST_I_WAIT: begin
				if (sts.div_done) begin
					cmd.sum_add_i = 1'b1;
					state_d       = ST_D_SCALE;
				end
			end
			ST_D_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wpid_pkg::MUL_DER_SCALE;
				state_d     = ST_D_GAIN;
			end
			ST_D_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wpid_pkg::MUL_DER_GAIN;
				state_d     = ST_D_DIV;
			end
			ST_D_DIV: begin
				if (sts.ms_zero) begin
					state_d = ST_PID;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = wpid_pkg::DIV_DER;
					state_d       = ST_D_WAIT;
				end
			end
			ST_D_WAIT: begin
				if (sts.div_done) begin
					cmd.sum_add_d = 1'b1;
					state_d       = ST_PID;
				end
			end
			ST_PID: begin
				cmd.pid_load = 1'b1;
				state_d      = ST_DUTY_MUL;
			end
			ST_DUTY_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wpid_pkg::MUL_DUTY;
				state_d     = ST_DUTY_DIV;
			end
			ST_DUTY_DIV: begin
				if (sts.duty_pos) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = wpid_pkg::DIV_DUTY;
					state_d       = ST_DUTY_WAIT;
				end else begin
					cmd.duty_zero = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_DUTY_WAIT: begin
				if (sts.div_done) begin
					cmd.duty_load = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

### src/wpid_dp.sv
// Datapath of the wheel PID speed controller: configuration, loop state,
// shared multiplier and output register. Uses wpid_pkg and wpid_div.
`default_nettype none

module wpid_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic signed [7:0]               speed_cmd,
	input  logic signed [12:0]              measured_rpm,
	input  logic [15:0]                     elapsed_ms,
	input  wpid_pkg::dp_cmd_t               cmd,
	output wpid_pkg::dp_sts_t               sts,
	output logic [15:0]                     pwm_duty,
	output logic                            dir_forward
);

	logic [15:0] prop_gain_q;
	logic [15:0] integ_gain_q;
	logic [15:0] deriv_gain_q;
	logic [11:0] rpm_range_q;
	logic [15:0] pwm_full_q;

	logic [7:0]         sp100_q;
	logic signed [12:0] meas_q;
	logic [15:0]        ms_q;

	logic signed [13:0] err_q;
	logic               tneg_q;
	logic signed [47:0] acc_q;
	logic signed [13:0] last_err_q;
	logic               fwd_q;
	logic [39:0]        prod_q;
	logic [63:0]        big_q;
	logic [56:0]        sum_q;
	logic [11:0]        pid_mag_q;
	logic               pos_q;
	logic [15:0]        duty_q;
	logic [15:0]        pwm_duty_q;
	logic               dir_q;

	logic signed [7:0]  s_sat;
	logic signed [8:0]  sp_sum;
	logic [13:0]        err_abs;
	logic [12:0]        err_mag;
	logic signed [14:0] diff;
	logic [14:0]        diff_abs;
	logic [13:0]        diff_mag;
	logic [47:0]        acc_abs;
	logic [46:0]        acc_mag;

	logic [15:0] mul_a;
	logic [23:0] mul_b;
	logic [39:0] mul_p;

	logic [63:0]                  div_dividend;
	logic [15:0]                  div_divisor;
	logic [wpid_pkg::STEP_W-1:0]  div_steps;
	logic                         div_done;
	logic [63:0]                  div_quo;

	logic signed [13:0] tgt;
	logic signed [13:0] err_new;
	logic signed [48:0] em_s;
	logic signed [48:0] acc_sum;
	logic signed [48:0] acc_hi;
	logic signed [48:0] acc_lo;
	logic signed [47:0] acc_new;
	logic [56:0]        p_ext;
	logic [56:0]        q_ext;
	logic [56:0]        sum_abs;
	logic [48:0]        sum_shr;
	logic [11:0]        pid_mag;

	always_comb begin
		if (speed_cmd > wpid_pkg::CMD_MAX) begin
			s_sat = wpid_pkg::CMD_MAX;
		end else if (speed_cmd < wpid_pkg::CMD_MIN) begin
			s_sat = wpid_pkg::CMD_MIN;
		end else begin
			s_sat = speed_cmd;
		end
		sp_sum = {s_sat[7], s_sat} + 9'sd100;

		err_abs  = err_q[13] ? 14'(-err_q) : err_q;
		err_mag  = err_abs[12:0];
		diff     = {err_q[13], err_q} - {last_err_q[13], last_err_q};
		diff_abs = diff[14] ? 15'(-diff) : diff;
		diff_mag = diff_abs[13:0];
		acc_abs  = acc_q[47] ? 48'(-acc_q) : acc_q;
		acc_mag  = acc_abs[46:0];
	end

	always_comb begin
		unique case (cmd.mul_sel)
			wpid_pkg::MUL_TGT: begin
				mul_a = {8'b0, sp100_q};
				mul_b = {12'b0, rpm_range_q};
			end
			wpid_pkg::MUL_ERR_MS: begin
				mul_a = ms_q;
				mul_b = {11'b0, err_mag};
			end
			wpid_pkg::MUL_PROP: begin
				mul_a = prop_gain_q;
				mul_b = {11'b0, err_mag};
			end
			wpid_pkg::MUL_INT_LO: begin
				mul_a = integ_gain_q;
				mul_b = acc_mag[23:0];
			end
			wpid_pkg::MUL_INT_HI: begin
				mul_a = integ_gain_q;
				mul_b = {1'b0, acc_mag[46:24]};
			end
			wpid_pkg::MUL_DER_SCALE: begin
				mul_a = wpid_pkg::MS_PER_S;
				mul_b = {10'b0, diff_mag};
			end
			wpid_pkg::MUL_DER_GAIN: begin
				mul_a = deriv_gain_q;
				mul_b = prod_q[23:0];
			end
			wpid_pkg::MUL_DUTY: begin
				mul_a = pwm_full_q;
				mul_b = {12'b0, pid_mag_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 40'(mul_a) * 40'(mul_b);
	end

	always_comb begin
		unique case (cmd.div_sel)
			wpid_pkg::DIV_TGT: begin
				div_dividend = {prod_q[19:0], 44'b0};
				div_divisor  = wpid_pkg::PCT_DIVISOR;
				div_steps    = wpid_pkg::STEPS_TGT;
			end
			wpid_pkg::DIV_INT: begin
				div_dividend = big_q;
				div_divisor  = wpid_pkg::MS_PER_S;
				div_steps    = wpid_pkg::STEPS_INT;
			end
			wpid_pkg::DIV_DER: begin
				div_dividend = {prod_q, 24'b0};
				div_divisor  = ms_q;
				div_steps    = wpid_pkg::STEPS_DER;
			end
			wpid_pkg::DIV_DUTY: begin
				div_dividend = {prod_q[27:0], 36'b0};
				div_divisor  = {4'b0, rpm_range_q};
				div_steps    = wpid_pkg::STEPS_DUTY;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
				div_steps    = '0;
			end
		endcase
	end

	wpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		tgt     = {1'b0, div_quo[12:0]} - {2'b0, rpm_range_q};
		err_new = tgt - {meas_q[12], meas_q};

		em_s    = err_q[13] ? -{19'b0, prod_q[29:0]} : {19'b0, prod_q[29:0]};
		acc_sum = {acc_q[47], acc_q} + em_s;
		acc_hi  = {wpid_pkg::ACC_POS_LIM[47], wpid_pkg::ACC_POS_LIM};
		acc_lo  = {wpid_pkg::ACC_NEG_LIM[47], wpid_pkg::ACC_NEG_LIM};
		if (acc_sum > acc_hi) begin
			acc_new = wpid_pkg::ACC_POS_LIM;
		end else if (acc_sum < acc_lo) begin
			acc_new = wpid_pkg::ACC_NEG_LIM;
		end else begin
			acc_new = acc_sum[47:0];
		end

		p_ext = {17'b0, prod_q};
		q_ext = {1'b0, div_quo[55:0]};

		sum_abs = sum_q[56] ? 57'(-sum_q) : sum_q;
		sum_shr = sum_abs[56:8];
		if (sum_shr > {37'b0, rpm_range_q}) begin
			pid_mag = rpm_range_q;
		end else begin
			pid_mag = sum_shr[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= wpid_pkg::PROP_GAIN_RST;
			integ_gain_q <= wpid_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= wpid_pkg::DERIV_GAIN_RST;
			rpm_range_q  <= wpid_pkg::RPM_RANGE_RST;
			pwm_full_q   <= wpid_pkg::PWM_FULL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpid_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				wpid_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				wpid_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				wpid_pkg::REG_RPM_RANGE:  rpm_range_q  <= cfg_data[11:0];
				wpid_pkg::REG_PWM_FULL:   pwm_full_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			last_err_q <= '0;
			fwd_q      <= 1'b1;
		end else begin
			if (cmd.stop) begin
				acc_q      <= '0;
				last_err_q <= '0;
			end else if (cmd.acc_upd) begin
				acc_q <= acc_new;
			end
			if (cmd.pid_load) begin
				last_err_q <= err_q;
				fwd_q      <= !tneg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			sp100_q <= sp_sum[7:0];
			meas_q  <= measured_rpm;
			ms_q    <= elapsed_ms;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.tgt_load) begin
			err_q  <= err_new;
			tneg_q <= tgt[13];
		end
		if (cmd.int_hold) begin
			big_q <= {24'b0, prod_q};
		end else if (cmd.int_comb) begin
			big_q <= {prod_q, 24'b0} + big_q;
		end
		if (cmd.sum_load_p) begin
			sum_q <= err_q[13] ? 57'(-p_ext) : p_ext;
		end else if (cmd.sum_add_i) begin
			sum_q <= sum_q + (acc_q[47] ? 57'(-q_ext) : q_ext);
		end else if (cmd.sum_add_d) begin
			sum_q <= sum_q + (diff[14] ? 57'(-q_ext) : q_ext);
		end
		if (cmd.pid_load) begin
			pid_mag_q <= pid_mag;
			pos_q     <= (sum_q[56] == tneg_q) && (pid_mag != '0);
		end
		if (cmd.stop || cmd.duty_zero) begin
			duty_q <= '0;
		end else if (cmd.duty_load) begin
			duty_q <= div_quo[15:0];
		end
		if (cmd.out_load) begin
			pwm_duty_q <= duty_q;
			dir_q      <= fwd_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.cmd_zero = speed_cmd == '0;
	assign sts.ms_zero  = ms_q == '0;
	assign sts.duty_pos = pos_q;

	assign pwm_duty    = pwm_duty_q;
	assign dir_forward = dir_q;

endmodule

`default_nettype wire
